// ----- rtl/delta_v_charge_terminator_assert.svh -----
// Assertion macros for the charge terminator.
// Each macro checks on the rising edge of clk and is disabled while rst_n is low.
`ifndef DELTA_V_CHARGE_TERMINATOR_ASSERT_SVH
`define DELTA_V_CHARGE_TERMINATOR_ASSERT_SVH

// The consequence must hold in the same cycle as the antecedent.
`define DVCT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequence must hold in the cycle after the antecedent.
`define DVCT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/dvct_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package dvct_pkg;

  localparam int SAMPLE_BITS_DEF = 10;
  localparam int CFG_DATA_W      = 10;
  localparam int CFG_IDX_W       = 3;
  localparam int LEVEL_W         = 10;

  localparam logic [7:0]         SECONDS_PER_MINUTE  = 8'd60;
  localparam logic [7:0]         PULSE_SECONDS_RST   = 8'd30;
  localparam logic [7:0]         DROP_THRESHOLD_RST  = 8'd6;
  localparam logic [7:0]         TIMEOUT_MINUTES_RST = 8'd120;
  localparam logic [LEVEL_W-1:0] PRESENCE_LEVEL_RST  = 10'd400;
  localparam logic [LEVEL_W-1:0] FAULT_LEVEL_RST     = 10'd100;

  typedef enum logic [1:0] {
    PH_WAIT   = 2'd0,
    PH_CHARGE = 2'd1,
    PH_DONE   = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_START   = 3'd1,
    EV_DROP    = 3'd2,
    EV_TIMEOUT = 3'd3,
    EV_FAULT   = 3'd4,
    EV_REMOVED = 3'd5
  } event_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PULSE_SECONDS   = 3'd0,
    REG_DROP_THRESHOLD  = 3'd1,
    REG_TIMEOUT_MINUTES = 3'd2,
    REG_PRESENCE_LEVEL  = 3'd3,
    REG_FAULT_LEVEL     = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [7:0]         pulse_seconds;
    logic [7:0]         drop_threshold;
    logic [7:0]         timeout_minutes;
    logic [LEVEL_W-1:0] presence_level;
    logic [LEVEL_W-1:0] fault_level;
  } cfg_t;

endpackage
`default_nettype wire

// ----- rtl/dvct_cfg_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none
module dvct_cfg_regs (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [dvct_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [dvct_pkg::CFG_DATA_W-1:0] cfg_data,
  output dvct_pkg::cfg_t                       cfg
);

  dvct_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pulse_seconds   <= dvct_pkg::PULSE_SECONDS_RST;
      cfg_r.drop_threshold  <= dvct_pkg::DROP_THRESHOLD_RST;
      cfg_r.timeout_minutes <= dvct_pkg::TIMEOUT_MINUTES_RST;
      cfg_r.presence_level  <= dvct_pkg::PRESENCE_LEVEL_RST;
      cfg_r.fault_level     <= dvct_pkg::FAULT_LEVEL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dvct_pkg::REG_PULSE_SECONDS:   cfg_r.pulse_seconds   <= cfg_data[7:0];
        dvct_pkg::REG_DROP_THRESHOLD:  cfg_r.drop_threshold  <= cfg_data[7:0];
        dvct_pkg::REG_TIMEOUT_MINUTES: cfg_r.timeout_minutes <= cfg_data[7:0];
        dvct_pkg::REG_PRESENCE_LEVEL:  cfg_r.presence_level  <= cfg_data;
        dvct_pkg::REG_FAULT_LEVEL:     cfg_r.fault_level     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

// ----- rtl/dvct_step.sv -----
`timescale 1ns / 1ps
`default_nettype none
module dvct_step #(
  parameter int SAMPLE_BITS = dvct_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire dvct_pkg::cfg_t         cfg,
  input  wire logic                   step_en,
  input  wire logic [SAMPLE_BITS-1:0] sample,
  output dvct_pkg::phase_t            res_phase,
  output dvct_pkg::event_t            res_event,
  output logic [SAMPLE_BITS-1:0]      res_peak,
  output logic [SAMPLE_BITS-1:0]      res_drop,
  output logic [7:0]                  res_minutes
);

  localparam int CMP_W = (SAMPLE_BITS > dvct_pkg::LEVEL_W) ? SAMPLE_BITS : dvct_pkg::LEVEL_W;

  dvct_pkg::phase_t       phase_r, phase_nxt;
  logic [SAMPLE_BITS-1:0] peak_r, peak_nxt;
  logic [7:0]             seconds_r, seconds_nxt;
  logic [7:0]             minutes_r, minutes_nxt;

  logic [7:0]             sec_sum;
  logic [SAMPLE_BITS-1:0] peak_upd;
  logic [SAMPLE_BITS-1:0] drop;
  logic [CMP_W-1:0]       sample_w;
  logic [CMP_W-1:0]       presence_w;
  logic [CMP_W-1:0]       fault_w;
  logic [SAMPLE_BITS-1:0] thr_w;
  dvct_pkg::event_t       ev;

  always_comb begin
    sample_w   = CMP_W'(sample);
    presence_w = CMP_W'(cfg.presence_level);
    fault_w    = CMP_W'(cfg.fault_level);
    thr_w      = SAMPLE_BITS'(cfg.drop_threshold);
    sec_sum    = seconds_r + cfg.pulse_seconds;
    peak_upd   = (sample > peak_r) ? sample : peak_r;

    phase_nxt   = phase_r;
    peak_nxt    = peak_r;
    seconds_nxt = seconds_r;
    minutes_nxt = minutes_r;
    drop        = '0;
    ev          = dvct_pkg::EV_NONE;

    unique case (phase_r)
      dvct_pkg::PH_CHARGE: begin
        seconds_nxt = sec_sum;
        if (sample_w < fault_w) begin
          ev        = dvct_pkg::EV_FAULT;
          phase_nxt = dvct_pkg::PH_WAIT;
        end else begin
          peak_nxt = peak_upd;
          drop     = peak_upd - sample;
          if (sec_sum >= dvct_pkg::SECONDS_PER_MINUTE) begin
            seconds_nxt = sec_sum - dvct_pkg::SECONDS_PER_MINUTE;
            minutes_nxt = minutes_r + 8'd1;
          end
          if (drop >= thr_w) begin
            ev        = dvct_pkg::EV_DROP;
            phase_nxt = dvct_pkg::PH_DONE;
          end else if (minutes_nxt >= cfg.timeout_minutes) begin
            ev        = dvct_pkg::EV_TIMEOUT;
            phase_nxt = dvct_pkg::PH_DONE;
          end
        end
      end
      dvct_pkg::PH_DONE: begin
        if (sample_w <= presence_w) begin
          ev        = dvct_pkg::EV_REMOVED;
          phase_nxt = dvct_pkg::PH_WAIT;
        end
      end
      default: begin
        phase_nxt = dvct_pkg::PH_WAIT;
        if (sample_w >= presence_w) begin
          peak_nxt    = '0;
          seconds_nxt = '0;
          minutes_nxt = '0;
          if (cfg.drop_threshold == '0) begin
            ev        = dvct_pkg::EV_DROP;
            phase_nxt = dvct_pkg::PH_DONE;
          end else if (cfg.timeout_minutes == '0) begin
            ev        = dvct_pkg::EV_TIMEOUT;
            phase_nxt = dvct_pkg::PH_DONE;
          end else begin
            ev        = dvct_pkg::EV_START;
            phase_nxt = dvct_pkg::PH_CHARGE;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= dvct_pkg::PH_WAIT;
      peak_r    <= '0;
      seconds_r <= '0;
      minutes_r <= '0;
    end else if (step_en) begin
      phase_r   <= phase_nxt;
      peak_r    <= peak_nxt;
      seconds_r <= seconds_nxt;
      minutes_r <= minutes_nxt;
    end
  end

  assign res_phase   = phase_nxt;
  assign res_event   = ev;
  assign res_peak    = peak_nxt;
  assign res_drop    = drop;
  assign res_minutes = minutes_nxt;

endmodule
`default_nettype wire

// ----- rtl/delta_v_charge_terminator.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Minus-delta-V charge terminator for NiMH cells.
// Input channel: one averaged battery-voltage sample per transfer (in_valid/in_ready).
// Result channel: one result per sample (out_valid/out_ready) carrying the new
// phase, charge switch and LED drive, event code, peak, drop and minutes charged.
// Configuration: write cfg_data into register cfg_index when cfg_we is high;
// 0 pulse seconds, 1 drop threshold, 2 timeout minutes, 3 presence level,
// 4 fault level. Write only while no sample is in flight.
// Path: a sample is held in an input register, evaluated against the phase,
// peak and time counters, and lands in the output register, from which its
// result is offered.
// Throughput: one sample per cycle while out_ready is high; the state update loop sets this.
// Stall: while out_ready is low the result holds, the sample in the input
// register waits, and in_ready drops once both stages are full.
// Reset: phase waiting, peak, seconds and minutes zero, registers at defaults,
// both stages empty.
module delta_v_charge_terminator #(
  parameter int SAMPLE_BITS = dvct_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [SAMPLE_BITS-1:0]          in_sample,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic                                 out_switch_on,
  output logic                                 out_led_on,
  output logic [1:0]                           out_phase,
  output logic [2:0]                           out_event_res,
  output logic [SAMPLE_BITS-1:0]               out_peak_level,
  output logic [SAMPLE_BITS-1:0]               out_drop_level,
  output logic [7:0]                           out_minutes_charged,
  input  wire logic                            cfg_we,
  input  wire logic [dvct_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [dvct_pkg::CFG_DATA_W-1:0] cfg_data
);

  dvct_pkg::cfg_t         cfg;
  logic                   in_valid_r;
  logic [SAMPLE_BITS-1:0] in_sample_r;
  logic                   out_valid_r;
  logic                   adv;

  dvct_pkg::phase_t       res_phase;
  dvct_pkg::event_t       res_event;
  logic [SAMPLE_BITS-1:0] res_peak;
  logic [SAMPLE_BITS-1:0] res_drop;
  logic [7:0]             res_minutes;

  dvct_pkg::phase_t       out_phase_r;
  dvct_pkg::event_t       out_event_r;
  logic [SAMPLE_BITS-1:0] out_peak_r;
  logic [SAMPLE_BITS-1:0] out_drop_r;
  logic [7:0]             out_minutes_r;

  assign adv      = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || adv;

  dvct_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dvct_step #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_step (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .step_en     (adv),
    .sample      (in_sample_r),
    .res_phase   (res_phase),
    .res_event   (res_event),
    .res_peak    (res_peak),
    .res_drop    (res_drop),
    .res_minutes (res_minutes)
  );

  // hold the sample until it advances
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_sample_r <= in_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_phase_r   <= res_phase;
      out_event_r   <= res_event;
      out_peak_r    <= res_peak;
      out_drop_r    <= res_drop;
      out_minutes_r <= res_minutes;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_switch_on       = (out_phase_r == dvct_pkg::PH_CHARGE);
  assign out_led_on          = (out_phase_r == dvct_pkg::PH_DONE);
  assign out_phase           = out_phase_r;
  assign out_event_res       = out_event_r;
  assign out_peak_level      = out_peak_r;
  assign out_drop_level      = out_drop_r;
  assign out_minutes_charged = out_minutes_r;

`include "delta_v_charge_terminator_assert.svh"

  `DVCT_ASSERT_NEXT(a_adv_fills_out, adv, out_valid_r, "advanced sample did not reach output")
  `DVCT_ASSERT_SAME(a_fault_waits, out_valid_r && out_event_r == dvct_pkg::EV_FAULT, out_phase_r == dvct_pkg::PH_WAIT, "fault without return to waiting")
  `DVCT_ASSERT_SAME(a_drop_done, out_valid_r && out_event_r == dvct_pkg::EV_DROP, out_led_on && !out_switch_on, "drop end without done phase")

endmodule
`default_nettype wire
